// ----- rtl/pts_pkg.sv -----
// Shared types and constants for the priority/time-slice task scheduler.
package pts_pkg;

   localparam int TASK_SLOTS_DEFAULT    = 16;
   localparam int PROCESS_SLOTS_DEFAULT = 8;

   localparam int PRIO_W  = 8;
   localparam int TIMER_W = 16;

   localparam logic [PRIO_W-1:0] MIN_PRIORITY = 8'd5;
   localparam logic [PRIO_W-1:0] IDLE_SLICE   = 8'd20;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_SLEEP   = 2'd2,
      SLOT_SUSPEND = 2'd3
   } slot_state_type;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_SCHEDULE  = 3'd1,
      CMD_WRITE     = 3'd2,
      CMD_KILL      = 3'd3,
      CMD_IRQ_ENTER = 3'd4,
      CMD_IRQ_EXIT  = 3'd5,
      CMD_START     = 3'd6,
      CMD_NOP       = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_SLICE,
      ST_TICK_SCAN,
      ST_THREAD,
      ST_PROC,
      ST_REFILL,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      slot_state_type       state;
      logic [PRIO_W-1:0]    prio;
      logic [PRIO_W-1:0]    slice;
      logic [TIMER_W-1:0]   timer;
   } slot_entry_type;

   typedef struct packed {
      logic                 we_state;
      slot_state_type       state;
      logic                 we_prio;
      logic [PRIO_W-1:0]    prio;
      logic                 we_slice;
      logic [PRIO_W-1:0]    slice;
      logic                 we_timer;
      logic [TIMER_W-1:0]   timer;
   } slot_write_type;

   typedef struct packed {
      logic [TIMER_W-1:0]   dec;
      logic                 dec_zero;
      logic                 wins;
   } step_result_type;

endpackage

// ----- rtl/pts_slot_table.sv -----
// Task slot table: per-slot state, priority, slice and sleep timer.
module pts_slot_table #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT,
   parameter int IDX_W      = $clog2(TASK_SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IDX_W-1:0]       rd_addr,
   output pts_pkg::slot_entry_type rd_entry,
   input  logic [IDX_W-1:0]       wr_addr,
   input  pts_pkg::slot_write_type wr
);
   import pts_pkg::*;

   slot_state_type       state_ff [TASK_SLOTS];
   logic [PRIO_W-1:0]    prio_ff  [TASK_SLOTS];
   logic [PRIO_W-1:0]    slice_ff [TASK_SLOTS];
   logic [TIMER_W-1:0]   timer_ff [TASK_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            state_ff[i] <= (i == 0) ? SLOT_READY : SLOT_FREE;
            prio_ff[i]  <= (i == 0) ? IDLE_SLICE : '0;
            slice_ff[i] <= (i == 0) ? IDLE_SLICE : '0;
            timer_ff[i] <= '0;
         end
      end else begin
         if (wr.we_state) state_ff[wr_addr] <= wr.state;
         if (wr.we_prio)  prio_ff[wr_addr]  <= wr.prio;
         if (wr.we_slice) slice_ff[wr_addr] <= wr.slice;
         if (wr.we_timer) timer_ff[wr_addr] <= wr.timer;
      end
   end

   always_comb begin
      rd_entry.state = state_ff[rd_addr];
      rd_entry.prio  = prio_ff[rd_addr];
      rd_entry.slice = slice_ff[rd_addr];
      rd_entry.timer = timer_ff[rd_addr];
   end

endmodule

// ----- rtl/pts_step_unit.sv -----
// Shared step unit: decrement of one counter and best-so-far compare.
module pts_step_unit (
   input  logic [pts_pkg::TIMER_W-1:0] operand,
   input  logic                        best_valid,
   input  logic [pts_pkg::PRIO_W-1:0]  best,
   input  logic [pts_pkg::PRIO_W-1:0]  cand,
   output pts_pkg::step_result_type    result
);
   import pts_pkg::*;

   always_comb begin
      result.dec      = operand - 1'b1;
      result.dec_zero = (result.dec == '0);
      // an empty best (below zero) loses to any candidate
      result.wins     = !best_valid || (best < cand);
   end

endmodule

// ----- rtl/priority_timeslice_task_scheduler_core.sv -----
// Priority and time-slice task scheduler: sequencer, control registers and result stage.
//
// Usage: one command per request transaction on req_* (valid/ready), one result
// transaction on rsp_* for each. Commands: tick, schedule, write slot, kill,
// irq enter, irq exit, start, no-op.
// The block works on one request at a time; req_ready is high only while idle.
// Steps from the accepted request until rsp_valid is high:
//   commands that do not schedule, and suppressed schedules: finish only.
//   tick: one slice step, a walk of every slot, finish.
//   schedule, kill of the running slot, outermost irq exit: a thread walk, a
//   process walk if the thread walk finds no task, and if neither finds one a
//   refill walk over all slots followed by a second thread and process walk,
//   then finish. The shared step unit and the single slot-table read port set
//   the one-slot-per-cycle pace.
// req_ready rises together with rsp_valid, when the result is loaded into the
// output register, even while rsp_ready is low. A finished result waits in the
// sequencer until that register frees up, and the input stalls meanwhile.
// Reset (synchronous, active high) puts slot 0 ready with priority and slice
// 20, frees every other slot, and clears the running slot, irq depth, start.
module priority_timeslice_task_scheduler_core #(
   parameter int TASK_SLOTS    = pts_pkg::TASK_SLOTS_DEFAULT,
   parameter int PROCESS_SLOTS = pts_pkg::PROCESS_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_task_index,
   input  logic [1:0]  req_entry_state,
   input  logic [7:0]  req_entry_priority,
   input  logic [15:0] req_entry_timer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_current_task,
   output logic        rsp_switched,
   output logic [4:0]  rsp_woken_count,
   output logic        rsp_accepted
);
   import pts_pkg::*;

   localparam int IDX_W       = $clog2(TASK_SLOTS);
   localparam int CNT_W       = $clog2(TASK_SLOTS + 1);
   localparam bit HAS_THREADS = (PROCESS_SLOTS < TASK_SLOTS);
   localparam int PROC_END    = HAS_THREADS ? PROCESS_SLOTS : TASK_SLOTS;
   localparam logic [IDX_W-1:0] FIRST_PTR = HAS_THREADS ? IDX_W'(PROCESS_SLOTS) : IDX_W'(1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TASK_SLOTS - 1);
   localparam logic [IDX_W-1:0] LAST_PROC = IDX_W'(PROC_END - 1);
   localparam seq_state_type    FIRST_SCAN = HAS_THREADS ? ST_THREAD : ST_PROC;

   seq_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic               best_valid_ff, best_valid_in;
   logic [PRIO_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic               refilled_ff, refilled_in;
   logic [IDX_W-1:0]   running_ff, running_in;
   logic [7:0]         irq_depth_ff, irq_depth_in;
   logic               started_ff, started_in;
   logic [IDX_W-1:0]   before_ff, before_in;
   logic [CNT_W-1:0]   woken_ff, woken_in;
   logic               ok_ff, ok_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_task_ff, rsp_task_in;
   logic               rsp_switched_ff, rsp_switched_in;
   logic [4:0]         rsp_woken_ff, rsp_woken_in;
   logic               rsp_ok_ff, rsp_ok_in;

   cmd_type            cmd;
   logic               req_accept;
   logic               idx_in_range;
   logic [IDX_W-1:0]   req_slot;
   logic [7:0]         irq_dec;
   logic               sched_go;
   logic               out_free;

   logic [IDX_W-1:0]   rd_addr;
   slot_entry_type     rd_entry;
   logic [IDX_W-1:0]   wr_addr;
   slot_write_type     wr;

   logic [TIMER_W-1:0] operand;
   logic [PRIO_W-1:0]  cand;
   step_result_type    step;
   logic               scan_hit;
   logic               best_valid_next;
   logic [PRIO_W-1:0]  best_next;
   logic               best_positive;

   assign cmd          = cmd_type'(req_command);
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_accept   = req_valid && req_ready;
   assign idx_in_range = (32'(req_task_index) < 32'(TASK_SLOTS));
   assign req_slot     = IDX_W'(req_task_index);
   assign irq_dec      = irq_depth_ff - 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd)
         CMD_SCHEDULE: sched_go = started_ff && (irq_depth_ff == '0);
         CMD_KILL:     sched_go = idx_in_range && (req_slot != '0) &&
                                  (req_slot == running_ff) && started_ff &&
                                  (irq_depth_ff == '0);
         CMD_IRQ_EXIT: sched_go = started_ff && (irq_dec == '0);
         CMD_TICK, CMD_WRITE, CMD_IRQ_ENTER, CMD_START, CMD_NOP: sched_go = 1'b0;
         default:      sched_go = 1'b0;
      endcase
   end

   // shared unit operands
   assign rd_addr = (state_ff == ST_TICK_SLICE) ? running_ff : ptr_ff;
   assign operand = (state_ff == ST_TICK_SLICE) ? {8'b0, rd_entry.slice} : rd_entry.timer;
   assign cand    = (state_ff == ST_THREAD) ? rd_entry.prio : rd_entry.slice;

   pts_step_unit u_step (
      .operand    (operand),
      .best_valid (best_valid_ff),
      .best       (best_ff),
      .cand       (cand),
      .result     (step)
   );

   pts_slot_table #(
      .TASK_SLOTS (TASK_SLOTS),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_addr  (wr_addr),
      .wr       (wr)
   );

   assign scan_hit        = (rd_entry.state == SLOT_READY) && step.wins;
   assign best_valid_next = best_valid_ff || scan_hit;
   assign best_next       = scan_hit ? cand : best_ff;
   assign best_positive   = best_valid_next && (best_next != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (cmd == CMD_TICK) state_in = ST_TICK_SLICE;
               else if (sched_go)   state_in = FIRST_SCAN;
               else                 state_in = ST_FINISH;
            end
         end
         ST_TICK_SLICE: state_in = ST_TICK_SCAN;
         ST_TICK_SCAN: begin
            if (ptr_ff == LAST_SLOT) state_in = ST_FINISH;
         end
         ST_THREAD: begin
            if (ptr_ff == LAST_SLOT) state_in = best_positive ? ST_FINISH : ST_PROC;
         end
         ST_PROC: begin
            if (ptr_ff == LAST_PROC)
               state_in = (best_positive || refilled_ff) ? ST_FINISH : ST_REFILL;
         end
         ST_REFILL: begin
            if (ptr_ff == LAST_SLOT) state_in = FIRST_SCAN;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      ptr_in          = ptr_ff;
      best_valid_in   = best_valid_ff;
      best_in         = best_ff;
      pick_in         = pick_ff;
      refilled_in     = refilled_ff;
      running_in      = running_ff;
      irq_depth_in    = irq_depth_ff;
      started_in      = started_ff;
      before_in       = before_ff;
      woken_in        = woken_ff;
      ok_in           = ok_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_task_in     = rsp_task_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_woken_in    = rsp_woken_ff;
      rsp_ok_in       = rsp_ok_ff;
      wr_addr         = ptr_ff;
      wr              = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               before_in     = running_ff;
               woken_in      = '0;
               ok_in         = 1'b1;
               best_valid_in = 1'b0;
               best_in       = '0;
               pick_in       = '0;
               refilled_in   = 1'b0;
               ptr_in        = (cmd == CMD_TICK) ? '0 : FIRST_PTR;
               wr_addr       = req_slot;
               unique case (cmd)
                  CMD_WRITE: begin
                     if (idx_in_range) begin
                        wr.we_state = 1'b1;
                        wr.state    = slot_state_type'(req_entry_state);
                        wr.we_prio  = 1'b1;
                        wr.prio     = (req_entry_priority < MIN_PRIORITY) ?
                                      MIN_PRIORITY : req_entry_priority;
                        wr.we_slice = 1'b1;
                        wr.slice    = wr.prio;
                        wr.we_timer = 1'b1;
                        wr.timer    = req_entry_timer;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  CMD_KILL: begin
                     if (idx_in_range && (req_slot != '0)) begin
                        wr.we_state = 1'b1;
                        wr.state    = SLOT_FREE;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  CMD_IRQ_ENTER: irq_depth_in = irq_depth_ff + 1'b1;
                  CMD_IRQ_EXIT:  irq_depth_in = irq_dec;
                  CMD_START:     started_in   = 1'b1;
                  CMD_TICK, CMD_SCHEDULE, CMD_NOP: ;
                  default: ;
               endcase
            end
         end
         ST_TICK_SLICE: begin
            wr_addr = running_ff;
            if (rd_entry.slice != '0) begin
               wr.we_slice = 1'b1;
               wr.slice    = step.dec[PRIO_W-1:0];
            end
         end
         ST_TICK_SCAN: begin
            if (rd_entry.state == SLOT_SLEEP) begin
               wr.we_timer = 1'b1;
               wr.timer    = step.dec;
               if (step.dec_zero) begin
                  wr.we_state = 1'b1;
                  wr.state    = SLOT_READY;
                  woken_in    = woken_ff + 1'b1;
               end
            end
            ptr_in = ptr_ff + 1'b1;
         end
         ST_THREAD, ST_PROC: begin
            best_valid_in = best_valid_next;
            best_in       = best_next;
            if (scan_hit) pick_in = ptr_ff;
            ptr_in = ptr_ff + 1'b1;
            if ((state_ff == ST_THREAD) && (ptr_ff == LAST_SLOT)) begin
               if (best_positive) running_in = pick_in;
               else               ptr_in     = IDX_W'(1);
            end
            if ((state_ff == ST_PROC) && (ptr_ff == LAST_PROC)) begin
               if (best_positive)    running_in = pick_in;
               else if (refilled_ff) running_in = '0;
               else                  ptr_in     = '0;
            end
         end
         ST_REFILL: begin
            if (rd_entry.state == SLOT_READY) begin
               wr.we_slice = 1'b1;
               wr.slice    = rd_entry.prio;
            end
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST_SLOT) begin
               refilled_in = 1'b1;
               ptr_in      = FIRST_PTR;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_task_in     = 4'(running_ff);
               rsp_switched_in = (running_ff != before_ff);
               rsp_woken_in    = 5'(woken_ff);
               rsp_ok_in       = ok_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         running_ff    <= '0;
         irq_depth_ff  <= '0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         refilled_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         irq_depth_ff  <= irq_depth_in;
         started_ff    <= started_in;
         rsp_valid_ff  <= rsp_valid_in;
         refilled_ff   <= refilled_in;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      best_ff         <= best_in;
      pick_ff         <= pick_in;
      before_ff       <= before_in;
      woken_ff        <= woken_in;
      ok_ff           <= ok_in;
      rsp_task_ff     <= rsp_task_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_woken_ff    <= rsp_woken_in;
      rsp_ok_ff       <= rsp_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_current_task = rsp_task_ff;
   assign rsp_switched     = rsp_switched_ff;
   assign rsp_woken_count  = rsp_woken_ff;
   assign rsp_accepted     = rsp_ok_ff;

   // running slot moves only at the end of a thread or process walk
   a_running_from_scan: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (running_ff != $past(running_ff))) |->
      ($past(state_ff) == ST_THREAD || $past(state_ff) == ST_PROC))
      else $error("running slot changed outside a schedule walk");

   // a new result is loaded only from the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_FINISH))
      else $error("result loaded outside the finish state");

   // the refill walk runs at most once per schedule
   a_single_refill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REFILL) |-> !refilled_ff)
      else $error("second refill walk in one schedule");

   // the running slot stays inside the table
   a_running_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(running_ff) < 32'(TASK_SLOTS)))
      else $error("running slot outside the table");

endmodule
